@@ hdl/jse_pkg.sv @@
`default_nettype none

package jse_pkg;

    localparam int RunMax = 12;
    localparam int LenWidth = 4;

    localparam logic [1:0] ReqPoint  = 2'd0;
    localparam logic [1:0] ReqStart  = 2'd1;
    localparam logic [1:0] ReqEnd    = 2'd2;
    localparam logic [1:0] ReqUnused = 2'd3;

    localparam logic [6:0] QuoteReset = 7'd34;

    localparam logic [7:0] ChBackslash = 8'h5c;
    localparam logic [7:0] ChLowerB    = 8'h62;
    localparam logic [7:0] ChLowerF    = 8'h66;
    localparam logic [7:0] ChLowerN    = 8'h6e;
    localparam logic [7:0] ChLowerR    = 8'h72;
    localparam logic [7:0] ChLowerT    = 8'h74;
    localparam logic [7:0] ChLowerU    = 8'h75;
    localparam logic [7:0] ChLowerD    = 8'h64;

    localparam logic [6:0] CtlBackspace = 7'h08;
    localparam logic [6:0] CtlTab       = 7'h09;
    localparam logic [6:0] CtlNewline   = 7'h0a;
    localparam logic [6:0] CtlFormFeed  = 7'h0c;
    localparam logic [6:0] CtlReturn    = 7'h0d;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [20:0] code_point;
    } jse_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } jse_res_t;

    // one classified item: byte count and the bytes in emit order
    typedef struct packed {
        logic [LenWidth-1:0]        len;
        logic [RunMax-1:0][7:0]     bytes;
    } jse_cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
            r = 8'h30 + {4'b0, d};
        else
            r = 8'h57 + {4'b0, d};
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/jse_front.sv @@
`default_nettype none

module jse_front (
    input  wire jse_pkg::jse_req_t request,
    input  wire logic [6:0]        quote,
    output jse_pkg::jse_cmd_t      cmd,
    output logic                   has_bytes
);
    import jse_pkg::*;

    logic [20:0] v;
    logic [20:0] w;
    logic [20:0] off;
    logic        quote_hit;

    always_comb
    begin
        v = request.code_point;
        quote_hit = (quote != 7'd0) && (v == {14'b0, quote});
        // lone surrogate drops to its offset from the low end of the range
        if (v[20:11] == 10'b0000011011)
            w = {10'b0, v[10:0]};
        else
            w = v;
        off = w - 21'h010000;
        cmd.len = '0;
        cmd.bytes = '0;
        unique case (request.req_type)
            ReqPoint:
            begin
                priority if (quote_hit)
                begin
                    cmd.len = LenWidth'(2);
                    cmd.bytes[0] = ChBackslash;
                    cmd.bytes[1] = {1'b0, quote};
                end
                else if (w[20:7] == 14'd0)
                begin
                    unique case (w[6:0])
                        CtlBackspace:
                        begin
                            cmd.len = LenWidth'(2);
                            cmd.bytes[0] = ChBackslash;
                            cmd.bytes[1] = ChLowerB;
                        end
                        CtlFormFeed:
                        begin
                            cmd.len = LenWidth'(2);
                            cmd.bytes[0] = ChBackslash;
                            cmd.bytes[1] = ChLowerF;
                        end
                        CtlNewline:
                        begin
                            cmd.len = LenWidth'(2);
                            cmd.bytes[0] = ChBackslash;
                            cmd.bytes[1] = ChLowerN;
                        end
                        CtlReturn:
                        begin
                            cmd.len = LenWidth'(2);
                            cmd.bytes[0] = ChBackslash;
                            cmd.bytes[1] = ChLowerR;
                        end
                        CtlTab:
                        begin
                            cmd.len = LenWidth'(2);
                            cmd.bytes[0] = ChBackslash;
                            cmd.bytes[1] = ChLowerT;
                        end
                        default:
                        begin
                            cmd.len = LenWidth'(1);
                            cmd.bytes[0] = {1'b0, w[6:0]};
                        end
                    endcase
                end
                else if (w[20:8] == 13'd0)
                begin
                    cmd.len = LenWidth'(2);
                    cmd.bytes[0] = 8'hc0 | {6'b0, w[7:6]};
                    cmd.bytes[1] = 8'h80 | {2'b0, w[5:0]};
                end
                else if (w[20:16] == 5'd0)
                begin
                    cmd.len = LenWidth'(6);
                    cmd.bytes[0] = ChBackslash;
                    cmd.bytes[1] = ChLowerU;
                    cmd.bytes[2] = hex_char(w[15:12]);
                    cmd.bytes[3] = hex_char(w[11:8]);
                    cmd.bytes[4] = hex_char(w[7:4]);
                    cmd.bytes[5] = hex_char(w[3:0]);
                end
                else
                begin
                    // surrogate pair: high half d8xx..dbxx, low half dcxx..dfxx
                    cmd.len = LenWidth'(12);
                    cmd.bytes[0]  = ChBackslash;
                    cmd.bytes[1]  = ChLowerU;
                    cmd.bytes[2]  = ChLowerD;
                    cmd.bytes[3]  = hex_char({2'b10, off[19:18]});
                    cmd.bytes[4]  = hex_char(off[17:14]);
                    cmd.bytes[5]  = hex_char(off[13:10]);
                    cmd.bytes[6]  = ChBackslash;
                    cmd.bytes[7]  = ChLowerU;
                    cmd.bytes[8]  = ChLowerD;
                    cmd.bytes[9]  = hex_char({2'b11, off[9:8]});
                    cmd.bytes[10] = hex_char(off[7:4]);
                    cmd.bytes[11] = hex_char(off[3:0]);
                end
            end
            ReqStart, ReqEnd:
            begin
                if (quote != 7'd0)
                begin
                    cmd.len = LenWidth'(1);
                    cmd.bytes[0] = {1'b0, quote};
                end
            end
            default:
            begin
                cmd.len = '0;
            end
        endcase
        has_bytes = (cmd.len != '0);
    end

endmodule

`default_nettype wire

@@ hdl/jse_queue.sv @@
`default_nettype none

module jse_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr,
    input  wire jse_pkg::jse_cmd_t wr_data,
    input  wire logic              rd,
    output jse_pkg::jse_cmd_t      rd_data,
    output logic                   q_full,
    output logic                   q_empty
);
    import jse_pkg::*;

    localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntWidth = $clog2(DEPTH + 1);

    jse_cmd_t            mem_reg [DEPTH];
    logic [PtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    always_comb
    begin
        q_full  = (count_reg == CntWidth'(DEPTH));
        q_empty = (count_reg == '0);
        do_wr = wr && !q_full;
        do_rd = rd && !q_empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CntWidth'(do_wr) - CntWidth'(do_rd);
        rd_data = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntWidth'(DEPTH))
        else $error("queue count above depth");
    a_rd_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> !q_empty)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

@@ hdl/jse_back.sv @@
`default_nettype none

module jse_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire jse_pkg::jse_cmd_t head,
    input  wire logic              head_valid,
    output logic                   head_done,
    output jse_pkg::jse_res_t      result,
    output logic                   empty,
    input  wire logic              pop
);
    import jse_pkg::*;

    logic [LenWidth-1:0] idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    jse_res_t            out_reg, out_next;
    logic                advance, load, idx_last;

    always_comb
    begin
        advance = !out_valid_reg || pop;
        load = advance && head_valid;
        idx_last = (idx_reg == head.len - 1'b1);
        head_done = load && idx_last;
        idx_next = idx_reg;
        if (load)
            idx_next = idx_last ? '0 : idx_reg + 1'b1;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = head_valid;
        out_next = out_reg;
        if (load)
        begin
            out_next.out_byte = head.bytes[idx_reg];
            out_next.last_of_run = idx_last;
        end
        empty = !out_valid_reg;
        result = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < head.len))
        else $error("byte index past end of run");
    a_idx_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (idx_reg == '0))
        else $error("byte index nonzero with no item pending");
    a_done_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        head_done |=> (out_valid_reg && out_reg.last_of_run))
        else $error("run finished without last byte flagged");
`endif

endmodule

`default_nettype wire

@@ hdl/json_string_escaper.sv @@
// latency: an accepted item is written into the item queue, then its first byte is loaded into the output register
// throughput: one output byte per cycle while result is popped or empty, so one item per cycle for single-byte runs
// an item of n bytes (up to 12) holds the byte sequencer until all n bytes are loaded
// the item queue (QUEUE_DEPTH entries) lets input run ahead of a long escape
// reset: asynchronous active low, clears queue and output; quote_reg returns to 34
`default_nettype none

module json_string_escaper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire jse_pkg::jse_req_t request,
    input  wire logic              push,
    output logic                   full,
    output jse_pkg::jse_res_t      result,
    output logic                   empty,
    input  wire logic              pop,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [6:0]        cfg_data
);
    import jse_pkg::*;

    logic [6:0] quote_reg, quote_next;
    jse_cmd_t   front_cmd;
    jse_cmd_t   head_cmd;
    logic       front_has_bytes;
    logic       q_wr, q_rd, q_full, q_empty;

    always_comb
    begin
        cfg_ready = 1'b1;
        quote_next = (cfg_valid && cfg_ready) ? cfg_data : quote_reg;
        full = q_full;
        q_wr = push && !q_full && front_has_bytes;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quote_reg <= QuoteReset;
        else
            quote_reg <= quote_next;
    end

    jse_front u_front (
        .request   (request),
        .quote     (quote_reg),
        .cmd       (front_cmd),
        .has_bytes (front_has_bytes)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (front_cmd),
        .rd      (q_rd),
        .rd_data (head_cmd),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_valid (!q_empty),
        .head_done  (q_rd),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

`default_nettype wire
